// ----- rtl/mhpq_pkg.sv -----
package mhpq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;
    localparam int STATUS_W = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed;
        logic signed [VALUE_W-1:0] top;
        logic [COUNT_W-1:0]        count;
    } rsp_t;

endpackage

// ----- rtl/max_heap_priority_queue_top.sv -----
// Binary max-heap priority queue of signed 32-bit values held in one RAM of
// CAPACITY entries. A request either inserts a value (sift-up) or removes the
// maximum (the last entry moves to the root and sifts down); each request
// gives exactly one response with status, the removed value, the new top and
// the entry count. One request is worked on at a time and req_stall is high
// until it is finished. An insert climbs one level per pass through S_UP_RD
// and S_UP_CMP, a remove descends one level per pass through S_DN_RD,
// S_DN_PICK and S_DN_CMP, paced by the single shared comparator and the
// registered read of the heap RAM. A finished response waits in an output
// register, so the next request is taken while it waits.
// No clearing pass is needed after reset; only entries below the count are used.
module max_heap_priority_queue_top #(
    parameter int CAPACITY = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  mhpq_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output mhpq_pkg::rsp_t   rsp
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = ADDR_W + 2;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UP_RD   = 3'd1;
    localparam logic [2:0] S_UP_CMP  = 3'd2;
    localparam logic [2:0] S_DN_LAST = 3'd3;
    localparam logic [2:0] S_DN_RD   = 3'd4;
    localparam logic [2:0] S_DN_PICK = 3'd5;
    localparam logic [2:0] S_DN_CMP  = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   n_reg;
    logic [ADDR_W-1:0]                  pos_reg;
    logic [ADDR_W-1:0]                  pick_pos_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] val_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] pick_val_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] root_reg;
    logic signed [mhpq_pkg::VALUE_W-1:0] removed_reg;
    logic [mhpq_pkg::STATUS_W-1:0]      status_reg;
    logic                               has_rc_reg;
    logic                               rsp_valid_reg;
    mhpq_pkg::rsp_t                     rsp_reg;

    logic                               req_fire;
    logic                               fin_go;
    logic [CW-1:0]                      lc_w;
    logic [CW-1:0]                      rc_w;
    logic [CW-1:0]                      n_ext;
    logic [ADDR_W-1:0]                  parent_w;
    logic                               lc_out;
    logic                               pick_lc;

    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_waddr;
    logic [mhpq_pkg::VALUE_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]                  ram_raddr_a;
    logic [mhpq_pkg::VALUE_W-1:0]       ram_rdata_a;
    logic [mhpq_pkg::VALUE_W-1:0]       ram_rdata_b;

    logic signed [mhpq_pkg::VALUE_W-1:0] cmp_a;
    logic signed [mhpq_pkg::VALUE_W-1:0] cmp_b;
    logic                               cmp_less;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign fin_go    = (state_reg == S_FIN) && (!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign lc_w     = {1'b0, pos_reg, 1'b1};
    assign rc_w     = lc_w + CW'(1);
    assign n_ext    = CW'(n_reg);
    assign lc_out   = (lc_w >= n_ext);
    assign parent_w = (pos_reg - ADDR_W'(1)) >> 1;
    // without a right child the left one is taken; on equal keys the right one
    assign pick_lc  = !has_rc_reg || cmp_less;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (rc_w[ADDR_W-1:0]),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    mhpq_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .less (cmp_less)
    );

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  ram_raddr_a = ADDR_W'(count_reg - CNT_W'(1));
            S_UP_RD: ram_raddr_a = parent_w;
            S_DN_RD: ram_raddr_a = lc_w[ADDR_W-1:0];
            default: ram_raddr_a = pos_reg;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = ram_rdata_a;
            end
            S_DN_PICK:
            begin
                cmp_a = ram_rdata_b;
                cmp_b = ram_rdata_a;
            end
            default:
            begin
                cmp_a = val_reg;
                cmp_b = pick_val_reg;
            end
        endcase
    end

    // the moving value is held in val_reg and written once its slot is known
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = val_reg;
        unique case (state_reg)
            S_UP_RD:
            begin
                ram_we = (pos_reg == '0);
            end
            S_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmp_less ? val_reg : ram_rdata_a;
            end
            S_DN_RD:
            begin
                ram_we = lc_out;
            end
            S_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmp_less ? pick_val_reg : val_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == mhpq_pkg::KIND_INSERT)
                    begin
                        state_next = (count_reg >= CNT_W'(CAPACITY)) ? S_FIN : S_UP_RD;
                    end
                    else
                    begin
                        state_next = (count_reg <= CNT_W'(1)) ? S_FIN : S_DN_LAST;
                    end
                end
            end
            S_UP_RD:   state_next = (pos_reg == '0) ? S_FIN : S_UP_CMP;
            S_UP_CMP:  state_next = cmp_less ? S_FIN : S_UP_RD;
            S_DN_LAST: state_next = S_DN_RD;
            S_DN_RD:   state_next = lc_out ? S_FIN : S_DN_PICK;
            S_DN_PICK: state_next = S_DN_CMP;
            S_DN_CMP:  state_next = cmp_less ? S_DN_RD : S_FIN;
            S_FIN:     state_next = fin_go ? S_IDLE : S_FIN;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire)
            begin
                if (req.kind == mhpq_pkg::KIND_INSERT)
                begin
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                else if (count_reg != '0)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (fin_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= ram_wdata;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    removed_reg <= '0;
                    status_reg  <= mhpq_pkg::ST_OK;
                    if (req.kind == mhpq_pkg::KIND_INSERT)
                    begin
                        val_reg <= req.value;
                        pos_reg <= ADDR_W'(count_reg);
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            status_reg <= mhpq_pkg::ST_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_reg <= mhpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        removed_reg <= root_reg;
                        n_reg       <= count_reg - CNT_W'(1);
                    end
                end
            end
            S_UP_CMP:
            begin
                if (!cmp_less)
                begin
                    pos_reg <= parent_w;
                end
            end
            S_DN_LAST:
            begin
                val_reg <= ram_rdata_a;
                pos_reg <= '0;
            end
            S_DN_RD:
            begin
                has_rc_reg <= (rc_w < n_ext);
            end
            S_DN_PICK:
            begin
                pick_val_reg <= pick_lc ? ram_rdata_a : ram_rdata_b;
                pick_pos_reg <= pick_lc ? lc_w[ADDR_W-1:0] : rc_w[ADDR_W-1:0];
            end
            S_DN_CMP:
            begin
                if (cmp_less)
                begin
                    pos_reg <= pick_pos_reg;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    rsp_reg.status  <= status_reg;
                    rsp_reg.removed <= removed_reg;
                    rsp_reg.top     <= (count_reg != '0) ? root_reg : '0;
                    rsp_reg.count   <= mhpq_pkg::COUNT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_refused_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != mhpq_pkg::ST_OK) |-> rsp.removed == '0)
        else $error("refused request reports a removed value");

    a_sift_pos_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DN_RD |-> CW'(pos_reg) < n_ext)
        else $error("sift-down position outside heap");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer idle");

endmodule

// ----- rtl/mhpq_ram.sv -----
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/mhpq_cmp.sv -----
module mhpq_cmp (
    input  logic signed [mhpq_pkg::VALUE_W-1:0] a,
    input  logic signed [mhpq_pkg::VALUE_W-1:0] b,
    output logic                                less
);

    // signed compare shared by sift-up and both sift-down decisions
    assign less = (a < b);

endmodule

// ----- sim/heap_check_pkg.sv -----
package heap_check_pkg;

    import mhpq_pkg::*;

    class heap_scoreboard;

        logic signed [VALUE_W-1:0] heap_vals [];
        int unsigned               capacity;
        int unsigned               held;
        rsp_t                      pending_rsps [$];
        int                        failures;

        function new(int unsigned cap);
            capacity = cap;
            heap_vals = new[cap];
            held = 0;
            failures = 0;
        endfunction

        function void swap_entries(int unsigned a, int unsigned b);
            logic signed [VALUE_W-1:0] t;
            t = heap_vals[a];
            heap_vals[a] = heap_vals[b];
            heap_vals[b] = t;
        endfunction

        // accepted request: update the shadow heap and queue the expected response
        function void note_request(req_t r);
            rsp_t        e;
            int unsigned pos;
            int unsigned parent;
            int unsigned lc;
            int unsigned pick;
            e = '0;
            e.status = ST_OK;
            if (r.kind == KIND_INSERT) begin
                if (held >= capacity) begin
                    e.status = ST_FULL;
                end
                else begin
                    heap_vals[held] = r.value;
                    pos = held;
                    // equal keys climb past their parent
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (heap_vals[pos] < heap_vals[parent])
                            break;
                        swap_entries(pos, parent);
                        pos = parent;
                    end
                    held++;
                end
            end
            else if (held == 0) begin
                e.status = ST_EMPTY;
            end
            else begin
                e.removed = heap_vals[0];
                heap_vals[0] = heap_vals[held - 1];
                held--;
                pos = 0;
                while (2 * pos + 1 < held) begin
                    lc = 2 * pos + 1;
                    // right child wins ties
                    if (lc + 1 >= held || heap_vals[lc + 1] < heap_vals[lc])
                        pick = lc;
                    else
                        pick = lc + 1;
                    if (!(heap_vals[pos] < heap_vals[pick]))
                        break;
                    swap_entries(pos, pick);
                    pos = pick;
                end
            end
            e.top = (held > 0) ? heap_vals[0] : '0;
            e.count = held[COUNT_W-1:0];
            pending_rsps.push_back(e);
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (pending_rsps.size() == 0) begin
                $error("response transaction with nothing pending: status %0d top %0d count %0d",
                       a.status, a.top, a.count);
                failures++;
                return;
            end
            e = pending_rsps.pop_front();
            if (a.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, a.status);
                failures++;
            end
            if (a.removed !== e.removed) begin
                $error("removed: expected %0d, actual %0d", e.removed, a.removed);
                failures++;
            end
            if (a.top !== e.top) begin
                $error("top: expected %0d, actual %0d", e.top, a.top);
                failures++;
            end
            if (a.count !== e.count) begin
                $error("count: expected %0d, actual %0d", e.count, a.count);
                failures++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_rsps.size();
        endfunction

    endclass

endpackage

// ----- sim/tb_max_heap_priority_queue_top.sv -----
module tb_max_heap_priority_queue_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 128;
    localparam int TOTAL_OPS = 1150;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    mhpq_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    mhpq_pkg::rsp_t rsp;

    bit req_quiet = 1'b0;
    bit rsp_quiet = 1'b0;
    int ops_sent = 0;

    heap_check_pkg::heap_scoreboard sb = new(CAPACITY);

    always #5 clk = ~clk;

    max_heap_priority_queue_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    function automatic logic signed [mhpq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            5, 6:    return $signed($urandom_range(0, 15)) - 8;  // dense keys for ties
            7:       return 32'sh7fffffff - $signed($urandom_range(0, 3));
            8:       return 32'sh80000000 + $signed($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input logic kind,
                           input logic signed [mhpq_pkg::VALUE_W-1:0] value);
        mhpq_pkg::req_t r;
        int             gap;
        r.kind = kind;
        r.value = value;
        gap = req_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        sb.note_request(r);
        ops_sent++;
    endtask

    task automatic run_segment(input int len, input int insert_pct);
        repeat (len)
        begin
            if ($urandom_range(0, 99) < insert_pct)
                send_op(mhpq_pkg::KIND_INSERT, pick_value());
            else
                send_op(mhpq_pkg::KIND_REMOVE, $urandom);
        end
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty remove, extremes, ties on both sift directions
        send_op(mhpq_pkg::KIND_REMOVE, 32'sh0);
        send_op(mhpq_pkg::KIND_INSERT, 32'sh0);
        send_op(mhpq_pkg::KIND_INSERT, -32'sd1);
        send_op(mhpq_pkg::KIND_INSERT, 32'sh7fffffff);
        send_op(mhpq_pkg::KIND_INSERT, 32'sh80000000);
        send_op(mhpq_pkg::KIND_INSERT, 32'sh7fffffff);
        send_op(mhpq_pkg::KIND_INSERT, 32'sh55555555);
        send_op(mhpq_pkg::KIND_INSERT, 32'shaaaaaaaa);
        repeat (8) send_op(mhpq_pkg::KIND_REMOVE, 32'shffffffff);
        send_op(mhpq_pkg::KIND_INSERT, 32'sd9);
        send_op(mhpq_pkg::KIND_INSERT, 32'sd3);
        send_op(mhpq_pkg::KIND_INSERT, 32'sd3);
        send_op(mhpq_pkg::KIND_INSERT, 32'sd1);
        repeat (5) send_op(mhpq_pkg::KIND_REMOVE, 32'sh0);

        // fill past capacity, then drain past empty
        run_segment(CAPACITY + 7, 100);
        run_segment(CAPACITY + 12, 0);

        while (ops_sent < TOTAL_OPS)
        begin
            int pct;
            int len;
            case ($urandom_range(0, 2))
                0:       pct = 90;
                1:       pct = 10;
                default: pct = 50;
            endcase
            req_quiet = ($urandom_range(0, 3) == 0);
            len = $urandom_range(30, 150);
            if (len > TOTAL_OPS - ops_sent)
                len = TOTAL_OPS - ops_sent;
            run_segment(len, pct);
        end
        req_valid <= 1'b0;
        req_quiet = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : response_side
        int hold;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rsp_quiet = !rsp_quiet;
            hold = rsp_quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            sb.check_response(rsp);
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_cmp.sv
rtl/max_heap_priority_queue_top.sv
sim/heap_check_pkg.sv
sim/tb_max_heap_priority_queue_top.sv
